// ----- design/ppc_pkg.sv -----
// Shared types and constants for the portal plane crossing block.
package ppc_pkg;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int PART_W  = 7;
    localparam int NODE_W  = 11;
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int CNT_W   = 5;
    // |3 * 2^62 + 2^47| fits in 66 signed bits
    localparam int ACC_W   = 66;
    localparam int PROD_W  = 2 * COORD_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PART_W-1:0]  part_t;
    typedef logic signed [NODE_W-1:0]  node_t;
    typedef logic        [KIND_W-1:0]  kind_t;
    typedef logic        [SLOT_W-1:0]  slot_t;
    typedef logic        [CNT_W-1:0]   count_t;
    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    // Transaction kinds
    localparam kind_t KIND_QUERY = 2'd0;
    localparam kind_t KIND_PLANE = 2'd1;
    localparam kind_t KIND_SIDES = 2'd2;
    localparam kind_t KIND_DEACT = 2'd3;

    // Part code for "no part"
    localparam part_t PART_NONE = '1;

    // One plane row: normal and offset
    typedef struct packed {
        coord_t nx;
        coord_t ny;
        coord_t nz;
        coord_t w;
    } plane_t;

    // Front and back references of one portal
    typedef struct packed {
        part_t part_f;
        node_t node_f;
        part_t part_r;
        node_t node_r;
    } sides_t;

    // Table write strobes
    typedef struct packed {
        logic plane;
        logic sides;
        logic deact;
    } tbl_wr_t;

    // Multiply-accumulate control
    typedef struct packed {
        logic load;
        logic mul_en;
    } mac_ctrl_t;

endpackage

// ----- design/ppc_ifs.sv -----
// Request and response channel interfaces for the portal plane crossing block.
interface ppc_req_if;
    import ppc_pkg::*;

    logic   valid;
    logic   ready;
    kind_t  kind;
    slot_t  slot;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by;
    coord_t bz;
    part_t  part_a;
    node_t  node_a;
    part_t  part_b;
    node_t  node_b;

    modport source (output valid, kind, slot, ax, ay, az, bx, by, bz,
                    part_a, node_a, part_b, node_b, input ready);
    modport sink   (input valid, kind, slot, ax, ay, az, bx, by, bz,
                    part_a, node_a, part_b, node_b, output ready);
endinterface

interface ppc_rsp_if;
    import ppc_pkg::*;

    logic  valid;
    logic  ready;
    part_t new_part;
    node_t new_node;
    logic  crossed;

    modport source (output valid, new_part, new_node, crossed, input ready);
    modport sink   (input valid, new_part, new_node, crossed, output ready);
endinterface

// ----- design/ppc_table.sv -----
// Portal table: plane and side memories with registered read, active flags.
module ppc_table #(
    parameter int MAX_PORTALS = 16,
    parameter int AW          = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ppc_pkg::tbl_wr_t        wr,
    input  logic [AW-1:0]           wr_addr,
    input  ppc_pkg::plane_t         wr_plane,
    input  ppc_pkg::sides_t         wr_sides,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output ppc_pkg::plane_t         rd_plane,
    output ppc_pkg::sides_t         rd_sides,
    output logic [MAX_PORTALS-1:0]  active
);
    import ppc_pkg::*;

    plane_t                 plane_mem [MAX_PORTALS];
    sides_t                 sides_mem [MAX_PORTALS];
    plane_t                 rd_plane_reg;
    sides_t                 rd_sides_reg;
    logic [MAX_PORTALS-1:0] active_reg;

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (wr.plane)
        begin
            plane_mem[wr_addr] <= wr_plane;
        end
        if (wr.sides)
        begin
            sides_mem[wr_addr] <= wr_sides;
        end
        if (rd_en)
        begin
            rd_plane_reg <= plane_mem[rd_addr];
            rd_sides_reg <= sides_mem[rd_addr];
        end
    end

    // Active flags, cleared on reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (wr.sides)
        begin
            active_reg[wr_addr] <= 1'b1;
        end
        else if (wr.deact)
        begin
            active_reg[wr_addr] <= 1'b0;
        end
    end

    assign rd_plane = rd_plane_reg;
    assign rd_sides = rd_sides_reg;
    assign active   = active_reg;

endmodule

// ----- design/ppc_mac.sv -----
// Shared multiply-accumulate unit: registered 32x32 product, 66-bit accumulator.
module ppc_mac (
    input  logic                clk,
    input  logic                rst_n,
    input  ppc_pkg::mac_ctrl_t  ctrl,
    input  ppc_pkg::coord_t     opa,
    input  ppc_pkg::coord_t     opb,
    input  ppc_pkg::acc_t       init,
    output logic                acc_neg
);
    import ppc_pkg::*;

    prod_t prod_reg;
    logic  pv_reg;
    acc_t  acc_reg;

    // Product stage
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(opa) * PROD_W'(opb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= ctrl.mul_en;
        end
    end

    // Accumulate stage; load starts a new sum
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            acc_reg <= init;
        end
        else if (pv_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign acc_neg = acc_reg[ACC_W-1];

endmodule

// ----- design/portal_plane_crossing_update.sv -----
// Top level: portal table, query sequencer and shared multiply-accumulate unit.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------
//  req     | in  | valid / ready    | kind slot ax ay az bx by bz part_a node_a
//          |     |                  | part_b node_b
//  rsp     | out | valid / ready    | new_part new_node crossed
//  cfg     | in  | cfg_we           | cfg_data = portal_count
//
//  Table writes (kinds 1..3) give no response.
//  One multiplier is shared over six products per active portal.
//  A query with no current part answers without walking the table.
//  req.ready is low while a query runs or its response waits on rsp.ready.
//  Reset clears the active flags, portal_count and all control state.
module portal_plane_crossing_update #(
    parameter int MAX_PORTALS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    ppc_req_if.sink                req,
    ppc_rsp_if.source              rsp,
    input  logic                   cfg_we,
    input  logic [ppc_pkg::CNT_W-1:0] cfg_data
);
    import ppc_pkg::*;

    localparam int AW = (MAX_PORTALS > 1) ? $clog2(MAX_PORTALS) : 1;
    localparam int CW = $clog2(MAX_PORTALS + 1);
    localparam int LW = 9;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [3:0] STEP_B    = 4'd4;
    localparam logic [3:0] STEP_LAST = 4'd8;

    logic [1:0]             state_reg, state_next;
    logic [CW-1:0]          walk_reg, walk_next;
    logic [3:0]             step_reg, step_next;
    count_t                 count_reg;
    logic                   before_reg;
    coord_t                 a_reg [3];
    coord_t                 b_reg [3];
    part_t                  pa_reg;
    node_t                  na_reg;
    part_t                  part_out_reg;
    node_t                  node_out_reg;
    logic                   crossed_reg;

    logic                   req_fire;
    logic                   slot_ok;
    tbl_wr_t                tbl_wr;
    plane_t                 wr_plane;
    sides_t                 wr_sides;
    logic                   rd_en;
    plane_t                 rd_plane;
    sides_t                 rd_sides;
    logic [MAX_PORTALS-1:0] active;
    logic [CW-1:0]          n_lim;
    logic                   walk_done;
    logic                   walk_active;
    mac_ctrl_t              mac_ctrl;
    coord_t                 op_pos;
    coord_t                 op_nrm;
    acc_t                   mac_init;
    logic                   acc_neg;
    logic                   hit_f;
    logic                   hit_r;

    // Input handshake and table writes
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign slot_ok   = (LW'(req.slot) < LW'(MAX_PORTALS));

    assign tbl_wr.plane = req_fire && slot_ok && (req.kind == KIND_PLANE);
    assign tbl_wr.sides = req_fire && slot_ok && (req.kind == KIND_SIDES);
    assign tbl_wr.deact = req_fire && slot_ok && (req.kind == KIND_DEACT);

    assign wr_plane = '{nx: req.ax, ny: req.ay, nz: req.az, w: req.bx};
    assign wr_sides = '{part_f: req.part_a, node_f: req.node_a,
                        part_r: req.part_b, node_r: req.node_b};

    // Walk limit and current slot status
    assign n_lim = (LW'(count_reg) > LW'(MAX_PORTALS)) ? CW'(MAX_PORTALS)
                                                       : CW'(count_reg);
    assign walk_done   = (walk_reg >= n_lim);
    assign walk_active = active[walk_reg[AW-1:0]];
    assign rd_en       = (state_reg == ST_SCAN) && !walk_done && walk_active;

    ppc_table #(
        .MAX_PORTALS (MAX_PORTALS),
        .AW          (AW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .wr_addr  (AW'(req.slot)),
        .wr_plane (wr_plane),
        .wr_sides (wr_sides),
        .rd_en    (rd_en),
        .rd_addr  (walk_reg[AW-1:0]),
        .rd_plane (rd_plane),
        .rd_sides (rd_sides),
        .active   (active)
    );

    // Operand select: steps 0..2 previous position, 4..6 new position
    always_comb
    begin
        case (step_reg)
            4'd0:    begin op_pos = a_reg[0]; op_nrm = rd_plane.nx; end
            4'd1:    begin op_pos = a_reg[1]; op_nrm = rd_plane.ny; end
            4'd2:    begin op_pos = a_reg[2]; op_nrm = rd_plane.nz; end
            4'd4:    begin op_pos = b_reg[0]; op_nrm = rd_plane.nx; end
            4'd5:    begin op_pos = b_reg[1]; op_nrm = rd_plane.ny; end
            4'd6:    begin op_pos = b_reg[2]; op_nrm = rd_plane.nz; end
            default: begin op_pos = '0;       op_nrm = '0;          end
        endcase
    end

    // Sum starts at -(w * 2^16)
    assign mac_init = -{{(ACC_W - COORD_W - 16){rd_plane.w[COORD_W-1]}},
                        rd_plane.w, 16'b0};

    assign mac_ctrl.load   = (state_reg == ST_CALC) &&
                             ((step_reg == 4'd0) || (step_reg == STEP_B));
    assign mac_ctrl.mul_en = (state_reg == ST_CALC) &&
                             (step_reg != 4'd3) && (step_reg < 4'd7);

    ppc_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .opa     (op_pos),
        .opb     (op_nrm),
        .init    (mac_init),
        .acc_neg (acc_neg)
    );

    // Crossing tests, valid at the last step
    assign hit_f = (rd_sides.part_f == pa_reg) && !before_reg && acc_neg;
    assign hit_r = (rd_sides.part_r == pa_reg) && before_reg && !acc_neg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        walk_next  = walk_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.kind == KIND_QUERY))
                begin
                    walk_next  = '0;
                    state_next = (req.part_a == PART_NONE) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (walk_done)
                begin
                    state_next = ST_OUT;
                end
                else if (walk_active)
                begin
                    step_next  = '0;
                    state_next = ST_CALC;
                end
                else
                begin
                    walk_next = walk_reg + CW'(1);
                end
            end
            ST_CALC:
            begin
                if (step_reg == STEP_LAST)
                begin
                    if (hit_f || hit_r)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        walk_next  = walk_reg + CW'(1);
                        state_next = ST_SCAN;
                    end
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
            step_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            step_reg  <= step_next;
            if (cfg_we)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // Query capture, sign of first distance, response register
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            a_reg[0]     <= req.ax;
            a_reg[1]     <= req.ay;
            a_reg[2]     <= req.az;
            b_reg[0]     <= req.bx;
            b_reg[1]     <= req.by;
            b_reg[2]     <= req.bz;
            pa_reg       <= req.part_a;
            na_reg       <= req.node_a;
            part_out_reg <= req.part_a;
            node_out_reg <= req.node_a;
            crossed_reg  <= 1'b0;
        end
        if ((state_reg == ST_CALC) && (step_reg == STEP_B))
        begin
            before_reg <= acc_neg;
        end
        if ((state_reg == ST_CALC) && (step_reg == STEP_LAST))
        begin
            if (hit_f)
            begin
                part_out_reg <= rd_sides.part_r;
                node_out_reg <= rd_sides.node_r;
                crossed_reg  <= 1'b1;
            end
            else if (hit_r)
            begin
                part_out_reg <= rd_sides.part_f;
                node_out_reg <= rd_sides.node_f;
                crossed_reg  <= 1'b1;
            end
        end
    end

    assign rsp.valid    = (state_reg == ST_OUT);
    assign rsp.new_part = part_out_reg;
    assign rsp.new_node = node_out_reg;
    assign rsp.crossed  = crossed_reg;

`ifndef ASSERT_OFF
    // A response never waits while a new request is taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted while response pending");

    // Uncrossed response returns the query reference unchanged
    a_keep_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.crossed) |->
            (rsp.new_part == pa_reg) && (rsp.new_node == na_reg))
        else $error("reference changed without a crossing");

    // Arithmetic only runs on slots inside the walk limit
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (walk_reg < n_lim))
        else $error("portal walk past the slot limit");

    // A query with no current part never reports a crossing
    a_none_part: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (pa_reg == PART_NONE)) |-> !rsp.crossed)
        else $error("crossing reported for a query with no part");
`endif

endmodule

// ----- verif/tb_portal_plane_crossing_update.sv -----
// Testbench for portal_plane_crossing_update: table writes and move queries vs. a predictor.
module tb_portal_plane_crossing_update;
    import ppc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     PORTAL_SLOTS   = 16;
    localparam int     TAIL_CYCLES    = 20;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     HOLD_CYCLES    = 600;
    localparam int     HOLD_AFTER     = 700;
    localparam coord_t ONE            = 32'sh0001_0000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        kind_t  kind;
        slot_t  slot;
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by;
        coord_t bz;
        part_t  part_a;
        node_t  node_a;
        part_t  part_b;
        node_t  node_b;
    } req_item_t;

    typedef struct {
        part_t part;
        node_t node;
        logic  crossed;
    } move_result_t;

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we;
    count_t       cfg_data;

    ppc_req_if req_ch ();
    ppc_rsp_if rsp_ch ();

    portal_plane_crossing_update u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Predicted portal table and register
    plane_t       tbl_plane  [PORTAL_SLOTS];
    sides_t       tbl_sides  [PORTAL_SLOTS];
    bit           tbl_active [PORTAL_SLOTS];
    count_t       walk_count;

    // Stimulus side bookkeeping
    bit           plane_loaded [PORTAL_SLOTS];
    req_item_t    pend_items[$];
    move_result_t expected_moves[$];
    int           err_count    = 0;
    int           req_accepted = 0;

    // Handshake pacing state
    int           send_gap, send_calm, stall_left, stall_calm, idle_cycles;
    bit           hold_done;
    req_item_t    seen_req, next_req;
    move_result_t got_move, exp_move;

    // True when point p lies strictly behind the plane (p.n - w < 0), exact
    function automatic logic behind_plane(coord_t px, coord_t py, coord_t pz, plane_t pl);
        wide_t acc;
        acc = wide_t'(px) * wide_t'(pl.nx) + wide_t'(py) * wide_t'(pl.ny)
            + wide_t'(pz) * wide_t'(pl.nz) - (wide_t'(pl.w) <<< 16);
        return acc[127];
    endfunction

    // Update the predicted table, or predict the move for a query
    function automatic void apply_transaction(req_item_t it);
        move_result_t res;
        int           n;
        logic         a_neg, b_neg;
        case (it.kind)
            KIND_PLANE: tbl_plane[it.slot] = '{it.ax, it.ay, it.az, it.bx};
            KIND_SIDES:
            begin
                tbl_sides[it.slot]  = '{it.part_a, it.node_a, it.part_b, it.node_b};
                tbl_active[it.slot] = 1'b1;
            end
            KIND_DEACT: tbl_active[it.slot] = 1'b0;
            default:
            begin
                res = '{it.part_a, it.node_a, 1'b0};
                n   = (walk_count > PORTAL_SLOTS) ? PORTAL_SLOTS : int'(walk_count);
                if (it.part_a != PART_NONE)
                begin
                    for (int s = 0; s < n && !res.crossed; s++)
                    begin
                        if (tbl_active[s])
                        begin
                            a_neg = behind_plane(it.ax, it.ay, it.az, tbl_plane[s]);
                            b_neg = behind_plane(it.bx, it.by, it.bz, tbl_plane[s]);
                            if (tbl_sides[s].part_f == it.part_a && !a_neg && b_neg)
                                res = '{tbl_sides[s].part_r, tbl_sides[s].node_r, 1'b1};
                            else if (tbl_sides[s].part_r == it.part_a && a_neg && !b_neg)
                                res = '{tbl_sides[s].part_f, tbl_sides[s].node_f, 1'b1};
                        end
                    end
                end
                expected_moves.push_back(res);
            end
        endcase
    endfunction

    // Gap length: mostly none or short, a few long, with calm stretches
    function automatic int next_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic coord_t near_coord(int units);
        return coord_t'(int'($urandom_range(0, 2 * units * 65536)) - units * 65536);
    endfunction

    function automatic coord_t mixed_coord(int units);
        return ($urandom_range(0, 9) == 0) ? coord_t'($urandom) : near_coord(units);
    endfunction

    // Few distinct parts so that portal sides match often
    function automatic part_t pick_part();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return PART_NONE;
        if (r < 12)
            return part_t'($urandom);
        return part_t'($urandom_range(0, 3));
    endfunction

    // Transaction with every payload field random
    function automatic req_item_t raw_item(kind_t k, slot_t s);
        req_item_t it;
        it.kind   = k;
        it.slot   = s;
        it.ax     = coord_t'($urandom);
        it.ay     = coord_t'($urandom);
        it.az     = coord_t'($urandom);
        it.bx     = coord_t'($urandom);
        it.by     = coord_t'($urandom);
        it.bz     = coord_t'($urandom);
        it.part_a = part_t'($urandom);
        it.node_a = node_t'($urandom);
        it.part_b = part_t'($urandom);
        it.node_b = node_t'($urandom);
        return it;
    endfunction

    function automatic void enqueue(req_item_t it);
        if (it.kind == KIND_PLANE)
            plane_loaded[it.slot] = 1'b1;
        pend_items.push_back(it);
    endfunction

    function automatic void plane_item(slot_t s, coord_t nx, coord_t ny, coord_t nz, coord_t w);
        req_item_t it;
        it    = raw_item(KIND_PLANE, s);
        it.ax = nx;
        it.ay = ny;
        it.az = nz;
        it.bx = w;
        enqueue(it);
    endfunction

    function automatic void sides_item(slot_t s, part_t pf, node_t nf, part_t pr, node_t nr);
        req_item_t it;
        it        = raw_item(KIND_SIDES, s);
        it.part_a = pf;
        it.node_a = nf;
        it.part_b = pr;
        it.node_b = nr;
        enqueue(it);
    endfunction

    // Query with given x endpoints; y and z of both ends stay random
    function automatic void x_query(part_t p, node_t nd, coord_t x0, coord_t x1);
        req_item_t it;
        it        = raw_item(KIND_QUERY, slot_t'($urandom));
        it.part_a = p;
        it.node_a = nd;
        it.ax     = x0;
        it.bx     = x1;
        enqueue(it);
    endfunction

    // One random transaction; refs go only to slots whose plane is loaded
    function automatic void enqueue_random();
        req_item_t it;
        slot_t     s;
        int        r;
        s = slot_t'($urandom);
        r = $urandom_range(0, 99);
        if (r < 62)
        begin
            it        = raw_item(KIND_QUERY, s);
            it.part_a = pick_part();
            it.ax     = mixed_coord(100);
            it.ay     = mixed_coord(100);
            it.az     = mixed_coord(100);
            it.bx     = mixed_coord(100);
            it.by     = mixed_coord(100);
            it.bz     = mixed_coord(100);
            enqueue(it);
        end
        else if (r < 77)
        begin
            it    = raw_item(KIND_PLANE, s);
            it.ax = ($urandom_range(0, 7) == 0) ? coord_t'(0) : mixed_coord(4);
            it.ay = ($urandom_range(0, 7) == 0) ? coord_t'(0) : mixed_coord(4);
            it.az = ($urandom_range(0, 7) == 0) ? coord_t'(0) : mixed_coord(4);
            it.bx = mixed_coord(50);
            enqueue(it);
        end
        else if (r < 92)
        begin
            if (!plane_loaded[s])
                plane_item(s, mixed_coord(4), mixed_coord(4), mixed_coord(4), mixed_coord(50));
            it        = raw_item(KIND_SIDES, s);
            it.part_a = pick_part();
            it.part_b = pick_part();
            enqueue(it);
        end
        else
            enqueue(raw_item(KIND_DEACT, s));
    endfunction

    // Wait until nothing is queued, offered or outstanding, then let writes settle
    task automatic drain();
        @(negedge clk);
        while (pend_items.size() != 0 || req_ch.valid || expected_moves.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic set_portal_count(count_t v);
        drain();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        walk_count = v;
    endtask

    // Request driver: predicts each accepted transaction, then offers the next
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            send_gap     = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.kind   = req_ch.kind;
                seen_req.slot   = req_ch.slot;
                seen_req.ax     = req_ch.ax;
                seen_req.ay     = req_ch.ay;
                seen_req.az     = req_ch.az;
                seen_req.bx     = req_ch.bx;
                seen_req.by     = req_ch.by;
                seen_req.bz     = req_ch.bz;
                seen_req.part_a = req_ch.part_a;
                seen_req.node_a = req_ch.node_a;
                seen_req.part_b = req_ch.part_b;
                seen_req.node_b = req_ch.node_b;
                apply_transaction(seen_req);
                req_accepted++;
            end
            // a stalled transaction stays on the bus untouched
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pend_items.size() != 0)
                begin
                    next_req       = pend_items.pop_front();
                    req_ch.kind   <= next_req.kind;
                    req_ch.slot   <= next_req.slot;
                    req_ch.ax     <= next_req.ax;
                    req_ch.ay     <= next_req.ay;
                    req_ch.az     <= next_req.az;
                    req_ch.bx     <= next_req.bx;
                    req_ch.by     <= next_req.by;
                    req_ch.bz     <= next_req.bz;
                    req_ch.part_a <= next_req.part_a;
                    req_ch.node_a <= next_req.node_a;
                    req_ch.part_b <= next_req.part_b;
                    req_ch.node_b <= next_req.node_b;
                    req_ch.valid  <= 1'b1;
                    send_gap       = next_gap(send_calm);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: compare against the oldest predicted move
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_move = '{rsp_ch.new_part, rsp_ch.new_node, rsp_ch.crossed};
            if (expected_moves.size() == 0)
            begin
                $error("unexpected response: new_part %0d new_node %0d crossed %0b",
                       got_move.part, got_move.node, got_move.crossed);
                err_count++;
            end
            else
            begin
                exp_move = expected_moves.pop_front();
                if (got_move.part !== exp_move.part)
                begin
                    $error("new_part: expected %0d, got %0d", exp_move.part, got_move.part);
                    err_count++;
                end
                if (got_move.node !== exp_move.node)
                begin
                    $error("new_node: expected %0d, got %0d", exp_move.node, got_move.node);
                    err_count++;
                end
                if (got_move.crossed !== exp_move.crossed)
                begin
                    $error("crossed: expected %0b, got %0b", exp_move.crossed, got_move.crossed);
                    err_count++;
                end
            end
        end
    end

    // Response ready: random stalls, plus one long hold-off to back up the block
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left   = 0;
            hold_done    = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (!hold_done && req_accepted >= HOLD_AFTER)
        begin
            hold_done    = 1'b1;
            stall_left   = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (rsp_ch.valid && rsp_ch.ready)
        begin
            stall_left   = next_gap(stall_calm);
            rsp_ch.ready <= (stall_left == 0);
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            stall_left   = $urandom_range(1, 6);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        count_t    phase_count [7];
        int        phase_items [7];
        req_item_t it;

        phase_count   = '{5'd16, 5'd31, 5'd9, 5'd1, 5'd17, 5'd0, 5'd0};
        phase_items   = '{400, 350, 300, 300, 300, 60, 290};
        req_ch.valid  = 1'b0;
        req_ch.kind   = KIND_QUERY;
        req_ch.slot   = '0;
        req_ch.ax     = '0;
        req_ch.ay     = '0;
        req_ch.az     = '0;
        req_ch.bx     = '0;
        req_ch.by     = '0;
        req_ch.bz     = '0;
        req_ch.part_a = '0;
        req_ch.node_a = '0;
        req_ch.part_b = '0;
        req_ch.node_b = '0;
        rsp_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        walk_count    = '0;
        send_calm     = 0;
        stall_calm    = 0;
        idle_cycles   = 0;
        foreach (tbl_active[i])
        begin
            tbl_active[i]   = 1'b0;
            plane_loaded[i] = 1'b0;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nothing walked: count zero, no current part, one portal loaded but unseen
        set_portal_count(5'd0);
        x_query(part_t'(2), node_t'(1023), ONE, -ONE);
        x_query(PART_NONE, node_t'(-1024), ONE, -ONE);
        plane_item(4'd0, ONE, '0, '0, '0);
        sides_item(4'd0, part_t'(3), node_t'(7), part_t'(5), node_t'(9));
        x_query(part_t'(3), node_t'(1), ONE, -ONE);

        // Crossings both ways, touching the plane, wrong direction
        set_portal_count(5'd16);
        x_query(part_t'(3), node_t'(1), ONE, -ONE);
        x_query(part_t'(5), node_t'(2), -ONE, ONE);
        x_query(part_t'(3), node_t'(3), -ONE, ONE);
        x_query(part_t'(3), node_t'(4), '0, -ONE);
        x_query(part_t'(5), node_t'(5), -ONE, '0);
        x_query(part_t'(3), node_t'(6), ONE, '0);
        x_query(PART_NONE, node_t'(7), ONE, -ONE);

        // Extreme plane and references, negative part compared as ordinary
        plane_item(4'd15, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        sides_item(4'd15, part_t'(-64), node_t'(-1024), part_t'(63), node_t'(1023));
        it        = raw_item(KIND_QUERY, 4'd15);
        it.part_a = part_t'(-64);
        it.node_a = node_t'(0);
        it.ax     = 32'sh8000_0000;
        it.ay     = 32'sh8000_0000;
        it.az     = 32'sh8000_0000;
        it.bx     = 32'sh7FFF_FFFF;
        it.by     = 32'sh7FFF_FFFF;
        it.bz     = 32'sh7FFF_FFFF;
        enqueue(it);
        it.part_a = part_t'(63);
        it.ax     = 32'sh7FFF_FFFF;
        it.ay     = 32'sh7FFF_FFFF;
        it.az     = 32'sh7FFF_FFFF;
        it.bx     = 32'sh8000_0000;
        it.by     = 32'sh8000_0000;
        it.bz     = 32'sh8000_0000;
        enqueue(it);

        // Deactivate keeps the row; reactivation restores crossing
        enqueue(raw_item(KIND_DEACT, 4'd0));
        x_query(part_t'(3), node_t'(8), ONE, -ONE);
        sides_item(4'd0, part_t'(3), node_t'(7), part_t'(5), node_t'(9));
        x_query(part_t'(3), node_t'(9), ONE, -ONE);

        // Random phases over several counts, extremes included
        for (int p = 0; p < 7; p++)
        begin
            set_portal_count((p == 6) ? count_t'($urandom_range(0, 31)) : phase_count[p]);
            for (int i = 0; i < phase_items[p]; i++)
                enqueue_random();
        end

        drain();
        if (err_count == 0 && expected_moves.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
